### src/ric_pkg.sv
// Package for the receive ring chunker: kind, action and register codes,
// reset values and the command that passes from the front end to the back end.
// No dependencies.
package ric_pkg;

    localparam int CFG_W   = 11;
    localparam int IDX_W   = 2;
    localparam int LEN_W   = 7;
    localparam int LVL_W   = 11;
    localparam int CHUNK_W = 11;
    localparam int SIL_W   = 5;
    localparam int DROP_W  = 16;

    localparam logic [SIL_W-1:0]  SIL_MAX  = '1;
    localparam logic [DROP_W-1:0] DROP_MAX = '1;

    localparam logic [1:0] ACT_BYTE = 2'd0;
    localparam logic [1:0] ACT_TICK = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    localparam logic [IDX_W-1:0] CFG_WATERMARK = 2'd0;
    localparam logic [IDX_W-1:0] CFG_MAX_CHUNK = 2'd1;
    localparam logic [IDX_W-1:0] CFG_SILENCE   = 2'd2;

    localparam logic [CFG_W-1:0] WATERMARK_RST = 11'd256;
    localparam logic [CFG_W-1:0] MAX_CHUNK_RST = 11'd256;
    localparam logic [SIL_W-1:0] SILENCE_RST   = 5'd3;

    typedef enum logic [2:0] {
        K_ACK   = 3'd0,
        K_CHUNK = 3'd1,
        K_OVF   = 3'd2,
        K_READ  = 3'd3,
        K_EMPTY = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [CHUNK_W-1:0]  chunk;
        logic                sil;
        logic [LEN_W-1:0]    cnt;
        logic [LVL_W-1:0]    level;
        logic                ovf;
        logic [DROP_W-1:0]   drop;
    } t_cmd;

endpackage

### src/rx_ring_idle_chunker_top.sv
// Receive ring buffer with idle-timeout chunk events: top level.
// A byte, tick or other non-read request gives one result, registered after the command queue.
// A read of n bytes gives n results on consecutive cycles from the back end's ring port.
// busy rises only when the two-entry command queue is full; results cannot be stalled.
// Reset (synchronous, active low) clears pointers, counters, queue, config registers and the valid flag;
// ring contents are undefined until written.
module rx_ring_idle_chunker_top #(
    parameter int RING_BITS = 11,
    parameter int MAX_READ  = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_action,
    input  logic [7:0]                    i_rx_byte,
    input  logic [ric_pkg::LEN_W-1:0]     i_max_read_len,
    input  logic                          i_queue_accepts,
    input  logic                          i_cfg_we,
    input  logic [ric_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [ric_pkg::CFG_W-1:0]     i_cfg_wdata,
    output logic                          o_valid,
    output logic [2:0]                    o_kind,
    output logic [ric_pkg::CHUNK_W-1:0]   o_chunk_size,
    output logic                          o_silence_flag,
    output logic [7:0]                    o_read_byte,
    output logic                          o_last,
    output logic [ric_pkg::LVL_W-1:0]     o_rx_level,
    output logic                          o_overflowed,
    output logic [ric_pkg::DROP_W-1:0]    o_dropped_count
);
    import ric_pkg::*;

    localparam int QW = $bits(t_cmd) + RING_BITS;

    logic                 take, q_full, q_empty, pop;
    logic                 wr_en;
    logic [RING_BITS-1:0] wr_addr, f_addr, b_addr;
    logic [7:0]           wr_data;
    t_cmd                 f_cmd, b_cmd;
    logic [QW-1:0]        q_out;

    assign busy = q_full;
    assign take = start && !q_full;

    ric_front #(
        .RING_BITS (RING_BITS),
        .MAX_READ  (MAX_READ)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_action        (i_action),
        .i_rx_byte       (i_rx_byte),
        .i_max_read_len  (i_max_read_len),
        .i_queue_accepts (i_queue_accepts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_cmd           (f_cmd),
        .o_rd_addr       (f_addr),
        .o_wr_en         (wr_en),
        .o_wr_addr       (wr_addr),
        .o_wr_data       (wr_data)
    );

    ric_fifo #(
        .DW (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_data  ({f_addr, f_cmd}),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign b_cmd  = q_out[$bits(t_cmd)-1:0];
    assign b_addr = q_out[QW-1:$bits(t_cmd)];

    ric_back #(
        .RING_BITS (RING_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_cmd           (b_cmd),
        .i_cmd_addr      (b_addr),
        .o_pop           (pop),
        .i_wr_en         (wr_en),
        .i_wr_addr       (wr_addr),
        .i_wr_data       (wr_data),
        .o_valid         (o_valid),
        .o_kind          (o_kind),
        .o_chunk_size    (o_chunk_size),
        .o_silence_flag  (o_silence_flag),
        .o_read_byte     (o_read_byte),
        .o_last          (o_last),
        .o_rx_level      (o_rx_level),
        .o_overflowed    (o_overflowed),
        .o_dropped_count (o_dropped_count)
    );

endmodule

### src/ric_front.sv
// Front end of the receive ring chunker: takes requests, updates the ring
// pointers and counters, and issues one command per request. Uses ric_pkg.
module ric_front #(
    parameter int RING_BITS = 11,
    parameter int MAX_READ  = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  logic [1:0]                  i_action,
    input  logic [7:0]                  i_rx_byte,
    input  logic [ric_pkg::LEN_W-1:0]   i_max_read_len,
    input  logic                        i_queue_accepts,
    input  logic                        i_cfg_we,
    input  logic [ric_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [ric_pkg::CFG_W-1:0]   i_cfg_wdata,
    output ric_pkg::t_cmd               o_cmd,
    output logic [RING_BITS-1:0]        o_rd_addr,
    output logic                        o_wr_en,
    output logic [RING_BITS-1:0]        o_wr_addr,
    output logic [7:0]                  o_wr_data
);
    import ric_pkg::*;

    localparam int CMPW = (RING_BITS + 1 > CFG_W) ? RING_BITS + 1 : CFG_W;
    localparam logic [CMPW-1:0] RING_SIZE = CMPW'(1) << RING_BITS;
    localparam logic [CMPW-1:0] RING_HALF = RING_SIZE >> 1;
    localparam logic [LEN_W-1:0] READ_CAP = LEN_W'(MAX_READ);

    logic [RING_BITS-1:0] r_wp, r_rp, r_pp, r_lsw;
    logic [RING_BITS-1:0] n_wp, n_rp, n_pp, n_lsw;
    logic [SIL_W-1:0]     r_sil, n_sil;
    logic                 r_ovf, n_ovf;
    logic [DROP_W-1:0]    r_drop, n_drop;
    logic [CFG_W-1:0]     r_wm, r_mcs;
    logic [SIL_W-1:0]     r_st;

    logic [RING_BITS-1:0] used, avail, new_used;
    logic [CMPW-1:0]      free_x, avail_x, mcs_x, chunk_x, take_x, want_x, used_x, lvl_x;
    logic [SIL_W-1:0]     sil_cnt;
    logic [LEN_W-1:0]     want;
    logic                 event_hit;
    t_cmd                 cmd;

    always_comb begin
        used     = r_wp - r_rp;
        avail    = r_wp - r_pp;
        free_x   = RING_SIZE - CMPW'(used);
        avail_x  = CMPW'(avail);
        mcs_x    = CMPW'(r_mcs);
        chunk_x  = (avail_x < mcs_x) ? avail_x : mcs_x;
        want     = (i_max_read_len > READ_CAP) ? READ_CAP : i_max_read_len;
        want_x   = CMPW'(want);
        take_x   = (CMPW'(used) < want_x) ? CMPW'(used) : want_x;
        new_used = used - RING_BITS'(take_x);
        if (r_wp == r_lsw) begin
            sil_cnt = (r_sil == SIL_MAX) ? r_sil : r_sil + 1'b1;
        end else begin
            sil_cnt = '0;
        end

        n_wp      = r_wp;
        n_rp      = r_rp;
        n_pp      = r_pp;
        n_lsw     = r_lsw;
        n_sil     = r_sil;
        n_ovf     = r_ovf;
        event_hit = 1'b0;
        cmd       = '0;
        cmd.kind  = K_ACK;
        o_wr_en   = 1'b0;

        case (i_action)
            ACT_BYTE: begin
                if (!r_ovf) begin
                    o_wr_en = i_take;
                    n_wp    = r_wp + 1'b1;
                end
            end
            ACT_TICK: begin
                if (!r_ovf) begin
                    if (free_x <= CMPW'(r_wm)) begin
                        n_ovf     = 1'b1;
                        event_hit = 1'b1;
                        cmd.kind  = K_OVF;
                    end else begin
                        n_lsw = r_wp;
                        n_sil = sil_cnt;
                        if (sil_cnt >= r_st) begin
                            n_sil = '0;
                            if (avail != '0) begin
                                event_hit = 1'b1;
                                cmd.kind  = K_CHUNK;
                                cmd.sil   = 1'b1;
                                cmd.chunk = chunk_x[CHUNK_W-1:0];
                                n_pp      = r_pp + RING_BITS'(chunk_x);
                            end
                        end else if (avail_x >= mcs_x) begin
                            event_hit = 1'b1;
                            cmd.kind  = K_CHUNK;
                            cmd.chunk = r_mcs;
                            n_pp      = r_pp + RING_BITS'(mcs_x);
                        end
                    end
                end
            end
            ACT_READ: begin
                if (want != '0) begin
                    n_rp = r_rp + RING_BITS'(take_x);
                    if (r_ovf && (RING_SIZE - CMPW'(new_used) >= RING_HALF)) begin
                        n_ovf = 1'b0;
                    end
                end
                cmd.cnt  = take_x[LEN_W-1:0];
                cmd.kind = (take_x == '0) ? K_EMPTY : K_READ;
            end
            default: begin
                cmd.kind = K_ACK;
            end
        endcase

        n_drop = r_drop;
        if (event_hit && !i_queue_accepts && r_drop != DROP_MAX) begin
            n_drop = r_drop + 1'b1;
        end

        used_x    = CMPW'(RING_BITS'(n_wp - n_rp));
        lvl_x     = used_x;
        cmd.level = lvl_x[LVL_W-1:0];
        cmd.ovf   = n_ovf;
        cmd.drop  = n_drop;
    end

    assign o_cmd     = cmd;
    assign o_rd_addr = r_rp;
    assign o_wr_addr = r_wp;
    assign o_wr_data = i_rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_pp   <= '0;
            r_lsw  <= '0;
            r_sil  <= '0;
            r_ovf  <= 1'b0;
            r_drop <= '0;
        end else if (i_take) begin
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_pp   <= n_pp;
            r_lsw  <= n_lsw;
            r_sil  <= n_sil;
            r_ovf  <= n_ovf;
            r_drop <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wm  <= WATERMARK_RST;
            r_mcs <= MAX_CHUNK_RST;
            r_st  <= SILENCE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WATERMARK: r_wm  <= i_cfg_wdata;
                CFG_MAX_CHUNK: r_mcs <= i_cfg_wdata;
                CFG_SILENCE:   r_st  <= i_cfg_wdata[SIL_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

### src/ric_fifo.sv
// Two-entry command queue between the front end and the back end.
// No dependencies.
module ric_fifo #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output logic          o_empty,
    output logic          o_full
);
    logic [DW-1:0] r_mem [2];
    logic          r_wr_ptr, r_rd_ptr;
    logic [1:0]    r_cnt;

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### src/ric_back.sv
// Back end of the receive ring chunker: holds the ring memory, executes
// queued commands and drives the result registers. Uses ric_pkg.
module ric_back #(
    parameter int RING_BITS = 11
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  ric_pkg::t_cmd                 i_cmd,
    input  logic [RING_BITS-1:0]          i_cmd_addr,
    output logic                          o_pop,
    input  logic                          i_wr_en,
    input  logic [RING_BITS-1:0]          i_wr_addr,
    input  logic [7:0]                    i_wr_data,
    output logic                          o_valid,
    output logic [2:0]                    o_kind,
    output logic [ric_pkg::CHUNK_W-1:0]   o_chunk_size,
    output logic                          o_silence_flag,
    output logic [7:0]                    o_read_byte,
    output logic                          o_last,
    output logic [ric_pkg::LVL_W-1:0]     o_rx_level,
    output logic                          o_overflowed,
    output logic [ric_pkg::DROP_W-1:0]    o_dropped_count
);
    import ric_pkg::*;

    logic [7:0]           r_ring [2**RING_BITS];
    logic [7:0]           r_mem_q;
    logic                 r_rd_busy;
    logic [RING_BITS-1:0] r_addr;
    logic [LEN_W-1:0]     r_left;
    t_cmd                 r_meta;

    logic                 r_v, r_sel, r_last;
    t_cmd                 r_out;

    logic                 start_rd, rd_en;
    logic [RING_BITS-1:0] rd_a;

    assign o_pop    = !r_rd_busy && !i_q_empty;
    assign start_rd = o_pop && (i_cmd.kind == K_READ);
    assign rd_en    = r_rd_busy || start_rd;
    assign rd_a     = r_rd_busy ? r_addr : i_cmd_addr;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_ring[i_wr_addr] <= i_wr_data;
        end
        if (rd_en) begin
            r_mem_q <= r_ring[rd_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_busy <= 1'b0;
            r_v       <= 1'b0;
        end else begin
            r_v <= rd_en || o_pop;
            if (r_rd_busy) begin
                r_rd_busy <= (r_left != LEN_W'(1));
            end else if (start_rd) begin
                r_rd_busy <= (i_cmd.cnt != LEN_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_busy) begin
            r_addr <= r_addr + 1'b1;
            r_left <= r_left - 1'b1;
            r_sel  <= 1'b1;
            r_last <= (r_left == LEN_W'(1));
            r_out  <= r_meta;
        end else if (o_pop) begin
            r_addr <= i_cmd_addr + 1'b1;
            r_left <= i_cmd.cnt - 1'b1;
            r_meta <= i_cmd;
            r_sel  <= start_rd;
            r_last <= !start_rd || (i_cmd.cnt == LEN_W'(1));
            r_out  <= i_cmd;
        end
    end

    assign o_valid         = r_v;
    assign o_kind          = r_out.kind;
    assign o_chunk_size    = r_out.chunk;
    assign o_silence_flag  = r_out.sil;
    assign o_read_byte     = r_sel ? r_mem_q : 8'd0;
    assign o_last          = r_last;
    assign o_rx_level      = r_out.level;
    assign o_overflowed    = r_out.ovf;
    assign o_dropped_count = r_out.drop;

endmodule
